// ===== hdl/tlik_pkg.sv =====
// shared types, widths and constants of the two-link planar inverse kinematics solver
package tlik_pkg;

    localparam int COORD_FRAC_BITS = 4;
    localparam int COORD_W = 14;
    localparam int LEN_W = 9;
    localparam int OFF_W = 8;
    localparam int CFG_W = 9;
    localparam int CFG_IDX_W = 2;

    localparam int LINK_W = LEN_W + COORD_FRAC_BITS;
    localparam int LSQ_W = 2 * LINK_W;
    localparam int SUM_W = LINK_W + 1;
    localparam int SUMSQ_W = 2 * SUM_W;
    localparam int D2_W = 2 * COORD_W;
    localparam int NS_W = D2_W + 1;
    localparam int NA_W = NS_W - 1;
    localparam int DE_W = LSQ_W + 1;
    localparam int RAD_W = LSQ_W + D2_W + 2;
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W = ROOT_W + 3;
    localparam int SQ_CELLS = ROOT_W;

    localparam int XIN_W = NS_W;
    localparam int XY_W = 52;
    localparam int Z_W = 34;
    localparam int ACC_FRAC = 24;
    localparam int PRE_SHIFT = 20;
    localparam int MAX_STAGES = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd2;

    localparam logic signed [Z_W-1:0] Z_QUARTER = Z_W'(longint'(90) <<< ACC_FRAC);

    // atan(2^-i) in degrees, 24 fraction bits
    localparam logic signed [31:0] ATAN_TAB [MAX_STAGES] = '{
        32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
        32'sd60000934, 32'sd30029717, 32'sd15018523, 32'sd7509720,
        32'sd3754917, 32'sd1877466, 32'sd938734, 32'sd469367,
        32'sd234684, 32'sd117342, 32'sd58671, 32'sd29335,
        32'sd14668, 32'sd7334, 32'sd3667, 32'sd1833,
        32'sd917, 32'sd458, 32'sd229, 32'sd115
    };

    typedef enum logic [2:0] {
        STAT_FIRST  = 3'd0,
        STAT_SECOND = 3'd1,
        STAT_FAR    = 3'd2,
        STAT_CLOSE  = 3'd3,
        STAT_NONE   = 3'd4
    } status_t;

    typedef struct packed {
        status_t                    status;
        logic signed [COORD_W-1:0]  r;
        logic signed [COORD_W-1:0]  h;
        logic signed [NS_W-1:0]     ns;
        logic signed [NS_W-1:0]     ne;
    } side_t;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sq_lane_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   zero;
    } lane_t;

    // fold the vector into the right half-plane and scale it up
    function automatic lane_t pre_rotate(input logic signed [XIN_W-1:0] y,
                                         input logic signed [XIN_W-1:0] x);
        lane_t o;
        logic signed [XIN_W-1:0] xr;
        logic signed [XIN_W-1:0] yr;
        o.zero = (x == '0) && (y == '0);
        o.z = '0;
        xr = x;
        yr = y;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                xr = y;
                yr = -x;
                o.z = Z_QUARTER;
            end
            else
            begin
                xr = -y;
                yr = x;
                o.z = -Z_QUARTER;
            end
        end
        o.x = XY_W'(xr) <<< PRE_SHIFT;
        o.y = XY_W'(yr) <<< PRE_SHIFT;
        return o;
    endfunction

endpackage

// ===== hdl/tlik_sqrt_cell.sv =====
// one digit cell of the two-lane pipelined floor square root
module tlik_sqrt_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       valid_in,
    input  tlik_pkg::sq_lane_t [1:0]   lane_in,
    input  tlik_pkg::side_t            side_in,
    output logic                       valid_out,
    output tlik_pkg::sq_lane_t [1:0]   lane_out,
    output tlik_pkg::side_t            side_out
);
    import tlik_pkg::*;

    sq_lane_t [1:0] lane_next;

    always_comb
    begin
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        for (int l = 0; l < 2; l++)
        begin
            rem_sh = {lane_in[l].rem[REM_W-3:0], lane_in[l].rad[RAD_W-1 -: 2]};
            trial = {{(REM_W-ROOT_W-2){1'b0}}, lane_in[l].root, 2'b01};
            lane_next[l].rad = {lane_in[l].rad[RAD_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                lane_next[l].rem = rem_sh - trial;
                lane_next[l].root = {lane_in[l].root[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                lane_next[l].rem = rem_sh;
                lane_next[l].root = {lane_in[l].root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_out <= 1'b0;
        else if (en)
            valid_out <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_out <= lane_next;
            side_out <= side_in;
        end
    end

endmodule

// ===== hdl/tlik_cordic_cell.sv =====
// one vectoring cordic cell, three angle lanes side by side
module tlik_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    valid_in,
    input  tlik_pkg::lane_t [2:0]   lane_in,
    input  tlik_pkg::status_t       status_in,
    output logic                    valid_out,
    output tlik_pkg::lane_t [2:0]   lane_out,
    output tlik_pkg::status_t       status_out
);
    import tlik_pkg::*;

    lane_t [2:0] lane_next;
    logic signed [Z_W-1:0] angle_step;

    assign angle_step = Z_W'(ATAN_TAB[STAGE]);

    always_comb
    begin
        logic signed [XY_W-1:0] dx;
        logic signed [XY_W-1:0] dy;
        for (int l = 0; l < 3; l++)
        begin
            dx = lane_in[l].y >>> STAGE;
            dy = lane_in[l].x >>> STAGE;
            lane_next[l].zero = lane_in[l].zero;
            if (lane_in[l].y > 0)
            begin
                lane_next[l].x = lane_in[l].x + dx;
                lane_next[l].y = lane_in[l].y - dy;
                lane_next[l].z = lane_in[l].z + angle_step;
            end
            else
            begin
                lane_next[l].x = lane_in[l].x - dx;
                lane_next[l].y = lane_in[l].y + dy;
                lane_next[l].z = lane_in[l].z - angle_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_out <= 1'b0;
        else if (en)
            valid_out <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_out <= lane_next;
            status_out <= status_in;
        end
    end

endmodule

// ===== hdl/two_link_planar_ik.sv =====
// top level of the two-link planar inverse kinematics solver
//
// channel  dir  handshake             payload
// request  in   in_valid / in_ready   target_radial, target_height
// result   out  out_valid / out_ready solve_status, shoulder_servo_angle, elbow_servo_angle
// config   in   cfg_we                cfg_index, cfg_data
//
// one request per cycle unless a held result stalls the pipeline, through six setup stages,
// 28 square root digit cells, a fold stage, the cordic cells and two output stages
// the whole pipeline holds while a result waits in the output register
// reset clears the valid bits and loads the link lengths and the mount offset
module two_link_planar_ik #(
    parameter int ANGLE_FRAC_BITS = 8,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [tlik_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [tlik_pkg::CFG_W-1:0]             cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [tlik_pkg::COORD_W-1:0]    target_radial,
    input  logic signed [tlik_pkg::COORD_W-1:0]    target_height,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [2:0]                             solve_status,
    output logic [7:0]                             shoulder_servo_angle,
    output logic [7:0]                             elbow_servo_angle
);
    import tlik_pkg::*;

    localparam int ANG_W = ANGLE_FRAC_BITS + 10;
    localparam int S_W = ANGLE_FRAC_BITS + 12;
    localparam int DEG_W = 12;
    localparam int ROUND_SHIFT = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam logic signed [Z_W-1:0] ROUND_BIAS = Z_W'(longint'(1) <<< (ROUND_SHIFT - 1));
    localparam logic signed [S_W-1:0] HALF_TURN = S_W'(longint'(180) <<< ANGLE_FRAC_BITS);

    function automatic logic signed [ANG_W-1:0] round_angle(input lane_t l);
        logic signed [Z_W-1:0] zr;
        logic signed [Z_W-1:0] zs;
        zr = l.z + ROUND_BIAS;
        zs = zr >>> ROUND_SHIFT;
        return l.zero ? '0 : zs[ANG_W-1:0];
    endfunction

    // 90 minus the angle truncated toward zero
    function automatic logic signed [DEG_W-1:0] servo(input logic signed [S_W-1:0] v);
        logic signed [S_W-1:0] mag;
        logic signed [S_W-1:0] t;
        mag = (v < 0) ? -v : v;
        t = mag >>> ANGLE_FRAC_BITS;
        if (v < 0)
            t = -t;
        return DEG_W'(90) - t[DEG_W-1:0];
    endfunction

    function automatic logic in_range(input logic signed [DEG_W-1:0] a,
                                      input logic signed [DEG_W-1:0] b);
        return (a >= 0) && (a <= 180) && (b >= 0) && (b <= 180);
    endfunction

    logic en;

    // configuration and derived link terms
    logic [LEN_W-1:0]        upper_reg;
    logic [LEN_W-1:0]        lower_reg;
    logic signed [OFF_W-1:0] offset_reg;
    logic [LSQ_W-1:0]        l1sq_reg;
    logic [LSQ_W-1:0]        l2sq_reg;
    logic [SUMSQ_W-1:0]      sum2_reg;
    logic [SUMSQ_W-1:0]      dif2_reg;
    logic [DE_W-1:0]         de_reg;
    logic [2*DE_W-1:0]       de_sq_reg;
    logic [LINK_W-1:0]       l1;
    logic [LINK_W-1:0]       l2;
    logic [SUM_W-1:0]        link_sum;
    logic [LINK_W-1:0]       link_dif;

    assign l1 = {upper_reg, {COORD_FRAC_BITS{1'b0}}};
    assign l2 = {lower_reg, {COORD_FRAC_BITS{1'b0}}};
    assign link_sum = {1'b0, l1} + {1'b0, l2};
    assign link_dif = (l1 > l2) ? (l1 - l2) : (l2 - l1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg <= LEN_W'(114);
            lower_reg <= LEN_W'(204);
            offset_reg <= OFF_W'(28);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_UPPER:  upper_reg <= cfg_data;
                CFG_LOWER:  lower_reg <= cfg_data;
                CFG_OFFSET: offset_reg <= cfg_data[OFF_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        l1sq_reg <= l1 * l1;
        l2sq_reg <= l2 * l2;
        sum2_reg <= link_sum * link_sum;
        dif2_reg <= {2'b00, LSQ_W'(link_dif) * LSQ_W'(link_dif)};
        de_reg <= {LSQ_W'(l1) * LSQ_W'(l2), 1'b0};
        de_sq_reg <= de_reg * de_reg;
    end

    // setup stages
    logic                       s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic                       s4_valid_reg, s5_valid_reg, s6_valid_reg;
    logic signed [COORD_W-1:0]  s1_r_reg, s1_h_reg, s2_r_reg, s2_h_reg, s3_r_reg, s3_h_reg;
    logic signed [COORD_W-1:0]  s4_r_reg, s4_h_reg, s5_r_reg, s5_h_reg, s6_r_reg, s6_h_reg;
    logic [D2_W-2:0]            s1_rr_reg, s1_hh_reg;
    logic [D2_W-1:0]            s2_d2_reg;
    status_t                    s3_status_reg, s4_status_reg, s5_status_reg, s6_status_reg;
    logic signed [NS_W-1:0]     s3_ns_reg, s4_ns_reg, s5_ns_reg, s6_ns_reg;
    logic signed [NS_W-1:0]     s3_ne_reg, s4_ne_reg, s5_ne_reg, s6_ne_reg;
    logic [LSQ_W+D2_W-1:0]      s3_den_reg;
    logic [RAD_W-1:0]           s4_den2_reg, s5_den2_reg;
    logic [NA_W-1:0]            s4_na_reg;
    logic [RAD_W-1:0]           s5_na_sq_reg, s5_ne_sq_reg;
    logic [RAD_W-1:0]           s6_rad_s_reg, s6_rad_e_reg;

    logic signed [2*COORD_W-1:0] r_sq, h_sq;
    logic signed [2*NS_W-1:0]    ne_sq_full;
    logic signed [NS_W-1:0]      de_s;
    status_t                     status3;

    assign r_sq = target_radial * target_radial;
    assign h_sq = target_height * target_height;
    assign ne_sq_full = s4_ne_reg * s4_ne_reg;
    assign de_s = $signed({2'b00, de_reg});

    always_comb
    begin
        if (s2_d2_reg > sum2_reg)
            status3 = STAT_FAR;
        else if ((s2_d2_reg == '0) || (s2_d2_reg < dif2_reg))
            status3 = STAT_CLOSE;
        else
            status3 = STAT_FIRST; // solvable, choice made at the end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_r_reg <= target_radial;
            s1_h_reg <= target_height;
            s1_rr_reg <= r_sq[D2_W-2:0];
            s1_hh_reg <= h_sq[D2_W-2:0];

            s2_r_reg <= s1_r_reg;
            s2_h_reg <= s1_h_reg;
            s2_d2_reg <= {1'b0, s1_rr_reg} + {1'b0, s1_hh_reg};

            s3_r_reg <= s2_r_reg;
            s3_h_reg <= s2_h_reg;
            s3_status_reg <= status3;
            s3_ns_reg <= $signed(NS_W'(l1sq_reg) + NS_W'(s2_d2_reg) - NS_W'(l2sq_reg));
            s3_ne_reg <= $signed(NS_W'(l1sq_reg) + NS_W'(l2sq_reg) - NS_W'(s2_d2_reg));
            s3_den_reg <= l1sq_reg * s2_d2_reg;

            s4_r_reg <= s3_r_reg;
            s4_h_reg <= s3_h_reg;
            s4_status_reg <= s3_status_reg;
            s4_ns_reg <= s3_ns_reg;
            s4_na_reg <= (s3_ns_reg < 0) ? NA_W'(-s3_ns_reg) : NA_W'(s3_ns_reg);
            if (s3_ne_reg > de_s)
                s4_ne_reg <= de_s;
            else if (s3_ne_reg < -de_s)
                s4_ne_reg <= -de_s;
            else
                s4_ne_reg <= s3_ne_reg;
            s4_den2_reg <= {s3_den_reg, 2'b00};

            s5_r_reg <= s4_r_reg;
            s5_h_reg <= s4_h_reg;
            s5_status_reg <= s4_status_reg;
            s5_ns_reg <= s4_ns_reg;
            s5_ne_reg <= s4_ne_reg;
            s5_den2_reg <= s4_den2_reg;
            s5_na_sq_reg <= s4_na_reg * s4_na_reg;
            s5_ne_sq_reg <= ne_sq_full[RAD_W-1:0];

            s6_r_reg <= s5_r_reg;
            s6_h_reg <= s5_h_reg;
            s6_status_reg <= s5_status_reg;
            s6_ns_reg <= s5_ns_reg;
            s6_ne_reg <= s5_ne_reg;
            s6_rad_s_reg <= (s5_na_sq_reg < s5_den2_reg) ? (s5_den2_reg - s5_na_sq_reg) : '0;
            s6_rad_e_reg <= {2'b00, de_sq_reg} - s5_ne_sq_reg;
        end
    end

    // square root cells: lane 0 shoulder sine term, lane 1 elbow sine term
    sq_lane_t [1:0] sq_lane [SQ_CELLS+1];
    side_t          sq_side [SQ_CELLS+1];
    logic           sq_valid [SQ_CELLS+1];

    assign sq_valid[0] = s6_valid_reg;
    assign sq_side[0] = '{status: s6_status_reg, r: s6_r_reg, h: s6_h_reg,
                          ns: s6_ns_reg, ne: s6_ne_reg};
    assign sq_lane[0][0] = '{rad: s6_rad_s_reg, rem: '0, root: '0};
    assign sq_lane[0][1] = '{rad: s6_rad_e_reg, rem: '0, root: '0};

    for (genvar i = 0; i < SQ_CELLS; i++)
    begin : g_sqrt
        tlik_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (sq_valid[i]),
            .lane_in   (sq_lane[i]),
            .side_in   (sq_side[i]),
            .valid_out (sq_valid[i+1]),
            .lane_out  (sq_lane[i+1]),
            .side_out  (sq_side[i+1])
        );
    end

    // fold stage ahead of the cordic cells
    lane_t [2:0] co_lane [CORDIC_STAGES+1];
    status_t     co_status [CORDIC_STAGES+1];
    logic        co_valid [CORDIC_STAGES+1];
    side_t       sq_end;
    lane_t [2:0] pre_next;

    assign sq_end = sq_side[SQ_CELLS];
    assign pre_next[0] = pre_rotate(XIN_W'(sq_end.h), XIN_W'(sq_end.r));
    assign pre_next[1] = pre_rotate($signed({1'b0, sq_lane[SQ_CELLS][0].root}), sq_end.ns);
    assign pre_next[2] = pre_rotate($signed({1'b0, sq_lane[SQ_CELLS][1].root}), sq_end.ne);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            co_valid[0] <= 1'b0;
        else if (en)
            co_valid[0] <= sq_valid[SQ_CELLS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            co_lane[0] <= pre_next;
            co_status[0] <= sq_end.status;
        end
    end

    // lane 0 theta, lane 1 shoulder law-of-cosines angle, lane 2 elbow angle
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        tlik_cordic_cell #(
            .STAGE (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .valid_in   (co_valid[i]),
            .lane_in    (co_lane[i]),
            .status_in  (co_status[i]),
            .valid_out  (co_valid[i+1]),
            .lane_out   (co_lane[i+1]),
            .status_out (co_status[i+1])
        );
    end

    // rounding stage
    logic                     f1_valid_reg;
    status_t                  f1_status_reg;
    logic signed [ANG_W-1:0]  f1_theta_reg, f1_phi_reg, f1_ae_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f1_valid_reg <= 1'b0;
        else if (en)
            f1_valid_reg <= co_valid[CORDIC_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_status_reg <= co_status[CORDIC_STAGES];
            f1_theta_reg <= round_angle(co_lane[CORDIC_STAGES][0]);
            f1_phi_reg <= round_angle(co_lane[CORDIC_STAGES][1]);
            f1_ae_reg <= round_angle(co_lane[CORDIC_STAGES][2]);
        end
    end

    // solution choice and output register
    logic                     out_valid_reg;
    logic [2:0]               out_status_reg;
    logic [7:0]               out_sa_reg, out_ea_reg;
    logic signed [S_W-1:0]    off_s, e1, s1, s2;
    logic signed [DEG_W-1:0]  sp1, ep1, sp2, ep2;
    status_t                  status_next;
    logic [7:0]               sa_next, ea_next;

    assign off_s = S_W'(offset_reg) <<< ANGLE_FRAC_BITS;
    assign e1 = HALF_TURN - S_W'(f1_ae_reg);
    assign s1 = S_W'(f1_theta_reg) + S_W'(f1_phi_reg) + off_s;
    assign s2 = S_W'(f1_theta_reg) - S_W'(f1_phi_reg) + off_s;
    assign sp1 = servo(s1);
    assign ep1 = servo(e1);
    assign sp2 = servo(s2);
    assign ep2 = servo(-e1);

    always_comb
    begin
        status_next = f1_status_reg;
        sa_next = '0;
        ea_next = '0;
        if (f1_status_reg == STAT_FIRST)
        begin
            if (in_range(sp1, ep1))
            begin
                sa_next = sp1[7:0];
                ea_next = ep1[7:0];
            end
            else if (in_range(sp2, ep2))
            begin
                status_next = STAT_SECOND;
                sa_next = sp2[7:0];
                ea_next = ep2[7:0];
            end
            else
                status_next = STAT_NONE;
        end
    end

    assign en = !out_valid_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= f1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_status_reg <= status_next;
            out_sa_reg <= sa_next;
            out_ea_reg <= ea_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign solve_status = out_status_reg;
    assign shoulder_servo_angle = out_sa_reg;
    assign elbow_servo_angle = out_ea_reg;

    // unsolved results carry zero angles
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (solve_status == STAT_FAR || solve_status == STAT_CLOSE ||
                      solve_status == STAT_NONE)
        |-> shoulder_servo_angle == '0 && elbow_servo_angle == '0)
        else $error("unsolved result with nonzero angle");

    // solved results stay within the servo travel
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (solve_status == STAT_FIRST || solve_status == STAT_SECOND)
        |-> shoulder_servo_angle <= 8'd180 && elbow_servo_angle <= 8'd180)
        else $error("servo angle beyond travel");

    // a held result freezes the pipeline and blocks new requests
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready ##1 $stable(f1_valid_reg))
        else $error("pipeline moved while result held");

endmodule

// ===== tb/two_link_planar_ik_test.sv =====
// testbench for the two-link planar inverse kinematics solver
`timescale 1ns / 100ps

module two_link_planar_ik_test;
    import tlik_pkg::*;

    localparam int LATENCY = 16 + 37;
    localparam longint CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [COORD_W-1:0] target_radial = '0;
    logic signed [COORD_W-1:0] target_height = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [2:0] solve_status;
    logic [7:0] shoulder_servo_angle;
    logic [7:0] elbow_servo_angle;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] shoulder;
        logic [7:0] elbow;
    } pose_t;

    pose_t pending_poses[$];
    int mismatches = 0;
    longint cycles = 0;
    int results_seen = 0;
    int sent = 0;
    bit idle_enable = 1'b1;

    // model copy of the registers
    logic [LEN_W-1:0] upper_len = 9'd114;
    logic [LEN_W-1:0] lower_len = 9'd204;
    logic signed [OFF_W-1:0] mount_off = 8'sd28;

    two_link_planar_ik dut (.*);

    always #2 clk = ~clk;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint cordic_angle(longint y, longint x);
        longint z = 0;
        longint t;
        longint dx;
        longint dy;
        if (x == 0 && y == 0) return 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y; y = -t; z = 90 * (64'sd1 << ACC_FRAC);
            end
            else
            begin
                x = -y; y = t; z = -90 * (64'sd1 << ACC_FRAC);
            end
        end
        x = x * (64'sd1 << PRE_SHIFT);
        y = y * (64'sd1 << PRE_SHIFT);
        for (int i = 0; i < 16; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y > 0)
            begin
                x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
            end
            else
            begin
                x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
            end
        end
        return floor_shift(z + (64'sd1 << (ACC_FRAC - 8 - 1)), ACC_FRAC - 8);
    endfunction

    function automatic longint whole_deg(longint v);
        if (v >= 0) return v >>> 8;
        return -((-v) >>> 8);
    endfunction

    function automatic bit servo_ok(longint a, longint b);
        return a >= 0 && a <= 180 && b >= 0 && b <= 180;
    endfunction

    function automatic pose_t solve_pose(longint r, longint h);
        pose_t p;
        longint l1 = longint'(upper_len) * 16;
        longint l2 = longint'(lower_len) * 16;
        longint d2 = r * r + h * h;
        longint sum = l1 + l2;
        longint dif = (l1 > l2) ? l1 - l2 : l2 - l1;
        longint theta, ns, phi, de, ne, ae, e1, off, sp1, ep1, sp2, ep2;
        longint unsigned den2, na, ss, ude;
        int k;
        p = '0;
        if (d2 > sum * sum)
            p.status = STAT_FAR;
        else if (d2 == 0 || d2 < dif * dif)
            p.status = STAT_CLOSE;
        else
        begin
            theta = cordic_angle(h, r);
            ns = l1 * l1 + d2 - l2 * l2;
            den2 = longint'(l1 * l1) * longint'(d2) * 4;
            na = (ns < 0) ? -ns : ns;
            ss = 0;
            if (na < (64'd1 << 32) && na * na < den2) ss = root_floor(den2 - na * na);
            phi = cordic_angle(longint'(ss), ns);
            ude = 2 * l1 * l2;
            k = 0;
            while ((ude >> k) >= (64'd1 << 31)) k++;
            de = longint'(ude >> k);
            ne = floor_shift(l1 * l1 + l2 * l2 - d2, k);
            if (ne > de) ne = de;
            if (ne < -de) ne = -de;
            ae = cordic_angle(longint'(root_floor(de * de - ne * ne)), ne);
            e1 = 180 * 256 - ae;
            off = longint'(mount_off) * 256;
            sp1 = 90 - whole_deg(theta + phi + off);
            ep1 = 90 - whole_deg(e1);
            sp2 = 90 - whole_deg(theta - phi + off);
            ep2 = 90 - whole_deg(-e1);
            if (servo_ok(sp1, ep1))
            begin
                p.status = STAT_FIRST; p.shoulder = sp1[7:0]; p.elbow = ep1[7:0];
            end
            else if (servo_ok(sp2, ep2))
            begin
                p.status = STAT_SECOND; p.shoulder = sp2[7:0]; p.elbow = ep2[7:0];
            end
            else
                p.status = STAT_NONE;
        end
        return p;
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n)
            out_ready <= !idle_enable || ($urandom_range(99) >= 9);

    // compare each returned pose with the oldest prediction
    always @(posedge clk)
    begin
        pose_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_poses.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result status=%0d", solve_status);
            end
            else
            begin
                want = pending_poses.pop_front();
                if (want.status !== solve_status || want.shoulder !== shoulder_servo_angle
                    || want.elbow !== elbow_servo_angle)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                                 want.status, want.shoulder, want.elbow, solve_status,
                                 shoulder_servo_angle, elbow_servo_angle);
                end
            end
        end
    end

    // valid stays high between back to back requests, drain drops it
    task automatic send_target(input logic signed [COORD_W-1:0] r,
                               input logic signed [COORD_W-1:0] h);
        while (idle_enable && $urandom_range(99) < 9)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        target_radial <= r;
        target_height <= h;
        pending_poses.push_back(solve_pose(r, h));
        do @(posedge clk); while (!in_ready);
        sent++;
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending_poses.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        if (idx == CFG_UPPER) upper_len = val;
        else if (idx == CFG_LOWER) lower_len = val;
        else if (idx == CFG_OFFSET) mount_off = val[7:0];
    endtask

    task automatic set_arm(input int l1, input int l2, input int off);
        drain();
        write_reg(CFG_UPPER, l1[8:0]);
        write_reg(CFG_LOWER, l2[8:0]);
        write_reg(CFG_OFFSET, {1'b0, off[7:0]});
        cfg_we <= 1'b0;
    endtask

    // targets near the reachable annulus, random elsewhere
    task automatic random_targets(input int count);
        int l1;
        int l2;
        int rad;
        int ang;
        logic signed [COORD_W-1:0] r;
        logic signed [COORD_W-1:0] h;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 75)
            begin
                l1 = upper_len * 16;
                l2 = lower_len * 16;
                rad = $urandom_range(l1 + l2 + 40, (l1 > l2 ? l1 - l2 : l2 - l1));
                if (rad > 8191) rad = $urandom_range(8191);
                ang = $urandom_range(3);
                r = COORD_W'((ang[0] ? rad : $urandom_range(rad))
                             * ($urandom_range(1) ? 1 : -1));
                h = COORD_W'((ang[0] ? $urandom_range(rad) : rad)
                             * ($urandom_range(1) ? 1 : -1));
            end
            else
            begin
                r = COORD_W'($urandom);
                h = COORD_W'($urandom);
            end
            send_target(r, h);
        end
    endtask

    task automatic test_directed;
        send_target(14'sd0, 14'sd0);
        send_target(14'sd8191, 14'sd8191);
        send_target(-14'sd8192, -14'sd8192);
        send_target(-14'sd8192, 14'sd8191);
        send_target(14'sd8191, -14'sd8192);
        send_target(14'sd4000, 14'sd1000);
        send_target(14'sd2000, 14'sd3000);
        send_target(-14'sd2000, 14'sd3000);
        send_target(14'sd0, 14'sd5088);
        send_target(14'sd5088, 14'sd0);
        send_target(14'sd1440, 14'sd0);
        send_target(14'sd1439, 14'sd0);
        send_target(14'sd5089, 14'sd0);
        send_target(14'sd3000, -14'sd2500);
        send_target(-14'sd100, -14'sd3000);
        send_target(14'sd1, 14'sd0);
    endtask

    task automatic test_reset_arm;
        random_targets(300);
    endtask

    task automatic test_extreme_arms;
        set_arm(511, 511, -90);
        test_directed();
        random_targets(200);
        set_arm(1, 1, 90);
        send_target(14'sd32, 14'sd0);
        send_target(14'sd0, 14'sd16);
        random_targets(150);
        set_arm(511, 1, 127);
        random_targets(150);
        set_arm(1, 300, -128);
        random_targets(150);
        set_arm(0, 200, 0);
        random_targets(100);
    endtask

    task automatic test_random_arms;
        for (int n = 0; n < 4; n++)
        begin
            set_arm($urandom_range(511, 1), $urandom_range(511, 1), $urandom_range(180) - 90);
            random_targets(100);
        end
    endtask

    task automatic test_no_idle;
        set_arm(114, 204, 28);
        idle_enable = 1'b0;
        random_targets(200);
        idle_enable = 1'b1;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_reset_arm();
        test_extreme_arms();
        test_random_arms();
        test_no_idle();
        drain();
        $display("sent %0d targets over several arm geometries and offsets, checked %0d poses",
                 sent, results_seen);
        if (mismatches == 0)
            $display("SUCCESS");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("FAILURE");
        end
        $finish;
    end
endmodule
